/* hdl/hae_pkg.sv */
// ----------------------------------------------------------------------------
// hae_pkg
// Shared types, character codes and helpers for the attribute value extractor.
// ----------------------------------------------------------------------------
package hae_pkg;

    // one character of attribute text
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
    } t_in_item;

    // one result transaction
    typedef struct packed {
        logic [7:0]  value_byte;
        logic        byte_valid;
        logic        done_res;
        logic        found;
        logic [15:0] value_length;
    } t_out_item;

    // configuration register indexes
    localparam logic [1:0] CFG_ATTR_NAME      = 2'd0;
    localparam logic [1:0] CFG_NAME_LENGTH    = 2'd1;
    localparam logic [1:0] CFG_VALUE_CAPACITY = 2'd2;

    localparam logic [15:0] CAPACITY_RESET = 16'd512;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    // whitespace: space, tab, LF, CR, FF and VT
    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
                (c == CH_CR) || (c == CH_FF) || (c == CH_VT);
    endfunction

    // ascii lower case
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        to_lower = ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ? (c + 8'd32) : c;
    endfunction

endpackage

/* hdl/hae_scan.sv */
// ----------------------------------------------------------------------------
// hae_scan
// Attribute scanner: per-character state update and result generation.
// ----------------------------------------------------------------------------
module hae_scan
    import hae_pkg::*;
#(
    parameter int NAME_MAX = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  t_in_item    i_item,
    input  logic [63:0] i_attr_name,
    input  logic [3:0]  i_name_length,
    input  logic [15:0] i_value_capacity,
    output logic        o_res_valid,
    output t_out_item   o_res
);

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_KEY,
        PH_AFTER_KEY,
        PH_AFTER_EQ,
        PH_VALUE
    } t_phase;

    typedef enum logic [1:0] {
        Q_NONE,
        Q_DOUBLE,
        Q_SINGLE
    } t_quote;

    localparam logic [3:0] NAME_MAX_C  = 4'(NAME_MAX);
    localparam logic [3:0] KEY_CNT_MAX = 4'd15;

    t_phase      r_phase,     n_phase;
    logic [3:0]  r_key_count, n_key_count;
    logic        r_key_equal, n_key_equal;
    t_quote      r_quote,     n_quote;
    logic [15:0] r_emitted,   n_emitted;
    logic        r_finished,  n_finished;

    logic [7:0]  c;
    logic        c_ws;
    logic [3:0]  kc_sel;
    logic [7:0]  name_byte;
    logic        char_match;
    logic        eq_after_key;
    logic        eq_empty_key;
    t_quote      q_eff;
    logic        term;
    logic        bv;
    logic        done;
    logic        fnd;
    logic        end_text;
    logic [15:0] len;

    assign c    = i_item.in_byte;
    assign c_ws = is_ws(c);

    // character compare against the wanted name, for a new key or the next char
    assign kc_sel    = (r_phase == PH_KEY) ? r_key_count : 4'd0;
    assign name_byte = i_attr_name[{kc_sel[2:0], 3'b000} +: 8];
    assign char_match = (kc_sel < NAME_MAX_C) && (kc_sel < i_name_length) &&
                        (to_lower(c) == to_lower(name_byte));

    // '=' closes the key: match needs full length and nonzero capacity
    assign eq_after_key = r_key_equal && (r_key_count == i_name_length) &&
                          (i_value_capacity != 16'd0);
    assign eq_empty_key = (i_name_length == 4'd0) && (i_value_capacity != 16'd0);

    // next state and result
    always_comb begin
        n_phase     = r_phase;
        n_key_count = r_key_count;
        n_key_equal = r_key_equal;
        n_quote     = r_quote;
        n_emitted   = r_emitted;
        n_finished  = r_finished;
        q_eff       = r_quote;
        term        = 1'b0;
        bv          = 1'b0;
        done        = 1'b0;
        fnd         = 1'b0;
        len         = 16'd0;
        end_text    = i_item.last;

        if (!r_finished) begin
            if (c == CH_NUL) begin
                end_text = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_SKIP, PH_AFTER_KEY: begin
                        if (c_ws) begin
                            // stay
                        end else if (c == CH_GT) begin
                            done = 1'b1;
                        end else if (c == CH_EQUAL) begin
                            if (r_phase == PH_SKIP) begin
                                n_key_count = 4'd0;
                                n_key_equal = eq_empty_key;
                            end else begin
                                n_key_equal = eq_after_key;
                            end
                            n_phase = PH_AFTER_EQ;
                        end else begin
                            n_key_count = 4'd1;
                            n_key_equal = char_match;
                            n_phase     = PH_KEY;
                        end
                    end
                    PH_KEY: begin
                        if (c_ws) begin
                            n_phase = PH_AFTER_KEY;
                        end else if (c == CH_EQUAL) begin
                            n_key_equal = eq_after_key;
                            n_phase     = PH_AFTER_EQ;
                        end else if (c == CH_GT) begin
                            done = 1'b1;
                        end else begin
                            n_key_equal = r_key_equal && char_match;
                            if (r_key_count < KEY_CNT_MAX) begin
                                n_key_count = r_key_count + 4'd1;
                            end
                        end
                    end
                    PH_AFTER_EQ, PH_VALUE: begin
                        if ((r_phase == PH_AFTER_EQ) && c_ws) begin
                            // skip space before the value
                        end else if ((r_phase == PH_AFTER_EQ) && (c == CH_DQUOTE)) begin
                            n_phase = PH_VALUE;
                            n_quote = Q_DOUBLE;
                        end else if ((r_phase == PH_AFTER_EQ) && (c == CH_SQUOTE)) begin
                            n_phase = PH_VALUE;
                            n_quote = Q_SINGLE;
                        end else begin
                            if (r_phase == PH_AFTER_EQ) begin
                                n_phase = PH_VALUE;
                                n_quote = Q_NONE;
                                q_eff   = Q_NONE;
                            end
                            case (q_eff)
                                Q_DOUBLE: term = (c == CH_DQUOTE);
                                Q_SINGLE: term = (c == CH_SQUOTE);
                                default:  term = c_ws || (c == CH_GT);
                            endcase
                            if (term) begin
                                if (r_key_equal) begin
                                    done = 1'b1;
                                    fnd  = 1'b1;
                                end else if ((q_eff == Q_NONE) && (c == CH_GT)) begin
                                    done = 1'b1;
                                end else begin
                                    n_phase = PH_SKIP;
                                    n_quote = Q_NONE;
                                end
                            end else if (r_key_equal &&
                                         ({1'b0, r_emitted} + 17'd1 <
                                          {1'b0, i_value_capacity})) begin
                                bv        = 1'b1;
                                n_emitted = r_emitted + 16'd1;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_SKIP;
                    end
                endcase
            end

            // closing report, at a terminator or at the end of the text
            if (done) begin
                n_finished = 1'b1;
            end else if (end_text) begin
                done       = 1'b1;
                fnd        = n_key_equal &&
                             ((n_phase == PH_AFTER_EQ) || (n_phase == PH_VALUE));
                n_finished = 1'b1;
            end

            // reported length, taken before any restart
            if (done && fnd) begin
                len = n_emitted;
            end
        end

        // end of text restarts the scan
        if (i_item.last) begin
            n_phase     = PH_SKIP;
            n_key_count = 4'd0;
            n_key_equal = 1'b1;
            n_quote     = Q_NONE;
            n_emitted   = 16'd0;
            n_finished  = 1'b0;
        end
    end

    // result fields
    assign o_res_valid        = i_fire && (bv || done);
    assign o_res.value_byte   = bv ? c : 8'd0;
    assign o_res.byte_valid   = bv;
    assign o_res.done_res     = done;
    assign o_res.found        = fnd;
    assign o_res.value_length = len;

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SKIP;
            r_key_count <= 4'd0;
            r_key_equal <= 1'b1;
            r_quote     <= Q_NONE;
            r_emitted   <= 16'd0;
            r_finished  <= 1'b0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_key_count <= n_key_count;
            r_key_equal <= n_key_equal;
            r_quote     <= n_quote;
            r_emitted   <= n_emitted;
            r_finished  <= n_finished;
        end
    end

    // a closing report without end of text leaves the scan finished
    a_done_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res.done_res && !i_item.last |=> r_finished)
        else $error("closing report did not finish the scan");

    // value bytes only come from the matched key
    a_byte_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res.byte_valid |-> r_key_equal && !r_finished)
        else $error("value byte emitted without a matched key");

    // a finished scan stays finished until more text is taken
    a_finished_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished && !i_fire |=> r_finished)
        else $error("finished flag dropped without a transaction");

endmodule

/* hdl/hae_out_stage.sv */
// ----------------------------------------------------------------------------
// hae_out_stage
// Result register with a skid entry; the scanner waits only once it fills.
// ----------------------------------------------------------------------------
module hae_out_stage
    import hae_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_res,
    output logic      o_ready,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    logic      r_out_valid;
    t_out_item r_out;
    logic      r_skid_valid;
    t_out_item r_skid;
    logic      pop;

    assign pop     = r_out_valid && !i_stall;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
                r_out       <= i_res;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
            r_skid       <= i_res;
        end
    end

    // the skid entry only fills behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // no push into a full stage
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("result pushed while skid entry is full");

    // a waiting skid entry is not dropped
    a_skid_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !pop |=> r_skid_valid && $stable(r_skid))
        else $error("skid entry lost while output stalled");

endmodule

/* hdl/html_attribute_value_extractor.sv */
// ----------------------------------------------------------------------------
// html_attribute_value_extractor
// Streams the value of one named HTML attribute out of a tag's attribute text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall / i_data) takes one text character per
//   transaction with a last flag on the final one. Output channel (o_valid /
//   i_stall / o_data) gives zero or one result per character: a value byte of
//   the wanted attribute, the closing found/length report, or both.
//   Configuration (i_cfg_we / i_cfg_idx / i_cfg_wdata) writes the wanted name,
//   its length and the value capacity; write only while no text is in flight.
// Timing:
//   One character per cycle sustained while the output is not stalled. A
//   character taken into the input register goes through the scanner and its
//   result is registered in the output register or the skid entry.
// Reset:
//   Synchronous, active low. Scan state goes to the start of an attribute
//   list, both channels empty; name 0, length 0, capacity 512.
// Stall:
//   A stalled result is held; one more result parks in the skid entry, after
//   which the scanner and then the input register hold and o_stall rises.
// ----------------------------------------------------------------------------
module html_attribute_value_extractor
    import hae_pkg::*;
#(
    parameter int NAME_MAX = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_wdata
);

    logic        r_in_valid;
    t_in_item    r_in;
    logic [63:0] r_attr_name;
    logic [3:0]  r_name_length;
    logic [15:0] r_value_capacity;

    logic        out_ready;
    logic        scan_fire;
    logic        res_valid;
    t_out_item   res;
    logic        in_accept;

    assign scan_fire = r_in_valid && out_ready;
    assign o_stall   = r_in_valid && !scan_fire;
    assign in_accept = i_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
            r_in       <= i_data;
        end else if (scan_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr_name      <= 64'd0;
            r_name_length    <= 4'd0;
            r_value_capacity <= CAPACITY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ATTR_NAME:      r_attr_name      <= i_cfg_wdata;
                CFG_NAME_LENGTH:    r_name_length    <= i_cfg_wdata[3:0];
                CFG_VALUE_CAPACITY: r_value_capacity <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    hae_scan #(
        .NAME_MAX (NAME_MAX)
    ) u_scan (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (scan_fire),
        .i_item           (r_in),
        .i_attr_name      (r_attr_name),
        .i_name_length    (r_name_length),
        .i_value_capacity (r_value_capacity),
        .o_res_valid      (res_valid),
        .o_res            (res)
    );

    hae_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_ready (out_ready),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule
